### hdl/fmgc_pkg.sv
// Package for the FIFO mutex grant coordinator.
// Holds field widths, the request struct and the status codes.
// No dependencies.
package fmgc_pkg;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int STAT_W  = 3;
  localparam int WCNT_W  = 5;
  localparam int ENTRY_W = ADDR_W + PORT_W;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } req_t;

  localparam logic [STAT_W-1:0] STAT_GRANTED      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_QUEUED       = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED      = 3'd2;
  localparam logic [STAT_W-1:0] STAT_RELEASE_IDLE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_RELEASE_NEXT = 3'd4;

endpackage

### hdl/fmgc_if.sv
// Channel interfaces: request messages in, status transactions out.
// Depends on fmgc_pkg.
interface fmgc_req_if import fmgc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] sender_addr;
  logic [PORT_W-1:0] sender_port;

  modport source (output valid, output sender_addr, output sender_port, input ready);
  modport sink   (input valid, input sender_addr, input sender_port, output ready);
endinterface

interface fmgc_rsp_if import fmgc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              grant_valid;
  logic [ADDR_W-1:0] grant_addr;
  logic [PORT_W-1:0] grant_port;
  logic [WCNT_W-1:0] waiting_count;

  modport source (output valid, output status, output grant_valid, output grant_addr,
                  output grant_port, output waiting_count, input ready);
  modport sink   (input valid, input status, input grant_valid, input grant_addr,
                  input grant_port, input waiting_count, output ready);
endinterface

### hdl/fmgc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/fmgc_front.sv
// Front end: accepts request transactions into a two-entry queue.
// Depends on fmgc_pkg and fmgc_req_if.
module fmgc_front import fmgc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fmgc_req_if.sink   req,
  output logic       q_valid,
  output req_t       q_data,
  input  logic       q_ready
);

  req_t       slots [2];
  logic       wr_idx;
  logic       rd_idx;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_data    = slots[rd_idx];
  assign pop       = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= '{addr: req.sender_addr, port: req.sender_port};
    end
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= ~wr_idx;
      end
      if (pop) begin
        rd_idx <= ~rd_idx;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hdl/fmgc_back.sv
// Back end: lock holder, circular wait queue in RAM, result register.
// Depends on fmgc_pkg, fmgc_rsp_if and fmgc_ram.
module fmgc_back import fmgc_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  req_t       q_data,
  output logic       q_ready,
  fmgc_rsp_if.source rsp
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state;
  logic              holder_valid;
  req_t              holder;
  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     wr_ptr;
  logic [CW-1:0]     count;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic              out_gvalid;
  req_t              out_grant;
  logic [WCNT_W-1:0] out_wcnt;

  logic              take;
  logic              is_release;
  logic              has_room;
  logic              ram_we;
  logic              ram_re;
  logic              load;
  logic [ENTRY_W-1:0] ram_rdata;
  req_t              head;

  function automatic logic [WCNT_W-1:0] to_wcnt(input logic [CW-1:0] c);
    logic [CW+WCNT_W-1:0] e;
    e = {{WCNT_W{1'b0}}, c};
    return e[WCNT_W-1:0];
  endfunction

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign take       = (state == ST_IDLE) && q_valid && (!out_valid || rsp.ready);
  assign q_ready    = take;
  assign is_release = holder_valid && (q_data == holder);
  assign has_room   = (count < CW'(QUEUE_DEPTH));
  assign ram_we     = take && holder_valid && !is_release && has_room;
  assign ram_re     = take && is_release && (count != '0);
  assign head       = ram_rdata;
  // A result is loaded on every take except a release that must first read the queue head.
  assign load       = (take && !ram_re) || (state == ST_READ);

  fmgc_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_wait_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (q_data),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.grant_valid   = out_gvalid;
  assign rsp.grant_addr    = out_grant.addr;
  assign rsp.grant_port    = out_grant.port;
  assign rsp.waiting_count = out_wcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      holder_valid <= 1'b0;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (!holder_valid) begin
              holder_valid <= 1'b1;
              holder       <= q_data;
              out_status   <= STAT_GRANTED;
              out_gvalid   <= 1'b1;
              out_grant    <= q_data;
              out_wcnt     <= to_wcnt(count);
            end else if (is_release) begin
              if (count != '0) begin
                state <= ST_READ;
              end else begin
                holder_valid <= 1'b0;
                out_status   <= STAT_RELEASE_IDLE;
                out_gvalid   <= 1'b0;
                out_grant    <= '0;
                out_wcnt     <= to_wcnt(count);
              end
            end else if (has_room) begin
              wr_ptr     <= bump(wr_ptr);
              count      <= count + 1'b1;
              out_status <= STAT_QUEUED;
              out_gvalid <= 1'b0;
              out_grant  <= '0;
              out_wcnt   <= to_wcnt(count + 1'b1);
            end else begin
              out_status <= STAT_DROPPED;
              out_gvalid <= 1'b0;
              out_grant  <= '0;
              out_wcnt   <= to_wcnt(count);
            end
          end
        end
        ST_READ: begin
          holder     <= head;
          rd_ptr     <= bump(rd_ptr);
          count      <= count - 1'b1;
          out_status <= STAT_RELEASE_NEXT;
          out_gvalid <= 1'b1;
          out_grant  <= head;
          out_wcnt   <= to_wcnt(count - 1'b1);
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("wait count beyond queue depth");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (count != '0))
    else $error("queue head read with empty queue");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (rd_ptr == wr_ptr))
    else $error("pointers differ with empty queue");

  a_grant_holder: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_gvalid) |-> holder_valid)
    else $error("grant pending without a holder");
`endif

endmodule

### hdl/fifo_mutex_grant_coordinator.sv
// Path: a result is registered in the front queue, then in the back-end result register;
//   a release that hands the lock to the head of the wait queue also passes through
//   ST_READ, where the registered read data of the wait-queue RAM is taken.
// Throughput: one request per cycle while the sink takes results; a release that grants
//   the next waiter holds the back end in ST_READ for the RAM's registered read port.
// Reset (rst, synchronous): clears holder, queue pointers, count and both channels;
//   wait-queue RAM contents are not cleared, entries are only read after being written.
module fifo_mutex_grant_coordinator import fmgc_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  fmgc_req_if.sink   req,
  fmgc_rsp_if.source rsp
);

  // Front end only buffers requests; all classification against the holder
  // happens in the back end, since it depends on every earlier transaction.
  logic q_valid;
  req_t q_data;
  logic q_ready;

  fmgc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready)
  );

  // Back end: compare against holder, push or pop the wait queue, and hold
  // the status transaction in an output register until the sink takes it.
  fmgc_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready),
    .rsp     (rsp)
  );

endmodule

### bench/tb_fifo_mutex_grant_coordinator.sv
`timescale 1ns / 100ps
// Self-checking bench for the FIFO mutex grant coordinator: directed table, then random traffic.
// Depends on fmgc_pkg, fmgc_if and the fifo_mutex_grant_coordinator RTL.
module tb_fifo_mutex_grant_coordinator;
  import fmgc_pkg::*;

  localparam int LOCK_DEPTH     = 16;
  localparam int STALL_MAX      = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 15;
  localparam int PHASE_ITEMS    = 60;
  localparam int POOL_SIZE      = 12;
  localparam int RING_W         = $clog2(LOCK_DEPTH);
  localparam int POOL_W         = $clog2(POOL_SIZE);
  localparam int FLIP_W         = $clog2(ENTRY_W);
  // Cycles to idle after the last status transaction; covers the release path through ST_READ.
  localparam int TAIL_CYCLES    = 8;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              grant_valid;
    logic [ADDR_W-1:0] grant_addr;
    logic [PORT_W-1:0] grant_port;
    logic [WCNT_W-1:0] waiting_count;
  } lock_result_t;

  // One row of the directed table: a message sent reps times, with an optional
  // hand-written expectation that replaces the predicted one.
  typedef struct {
    req_t         msg;
    int unsigned  reps;
    bit           typed;
    lock_result_t want;
  } plan_row_t;

  logic clk;
  logic rst;

  fmgc_req_if req_ch ();
  fmgc_rsp_if rsp_ch ();

  fifo_mutex_grant_coordinator #(.QUEUE_DEPTH(LOCK_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Lock predictor: current holder plus a circular queue of waiting requesters.
  req_t              wait_ring [LOCK_DEPTH];
  logic [RING_W-1:0] ring_rd    = '0;
  logic [RING_W-1:0] ring_wr    = '0;
  int unsigned       ring_count = 0;
  bit                lock_held  = 1'b0;
  req_t              lock_owner = '0;

  lock_result_t expected_results [$];
  lock_result_t oldest;
  plan_row_t    plan [$];
  req_t         requesters [POOL_SIZE];
  int unsigned  mismatches = 0;

  // Calm flags switch off idling on one side for a whole phase.
  bit feed_calm  = 1'b0;
  bit drain_calm = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Advance the lock by one message and return the status transaction it causes.
  function automatic lock_result_t advance_lock(input req_t m);
    lock_result_t r;
    r = '0;
    if (!lock_held) begin
      // Idle lock: grant the sender at once.
      lock_held     = 1'b1;
      lock_owner    = m;
      r.status      = STAT_GRANTED;
      r.grant_valid = 1'b1;
      r.grant_addr  = m.addr;
      r.grant_port  = m.port;
    end else if (m == lock_owner) begin
      // Holder speaks: release, and hand over to the oldest waiter if any.
      if (ring_count != 0) begin
        lock_owner    = wait_ring[ring_rd];
        ring_rd       = RING_W'((ring_rd + 1) % LOCK_DEPTH);
        ring_count--;
        r.status      = STAT_RELEASE_NEXT;
        r.grant_valid = 1'b1;
        r.grant_addr  = lock_owner.addr;
        r.grant_port  = lock_owner.port;
      end else begin
        lock_held  = 1'b0;
        lock_owner = '0;
        r.status   = STAT_RELEASE_IDLE;
      end
    end else if (ring_count < LOCK_DEPTH) begin
      // Anyone else waits; a repeat request takes a second slot.
      wait_ring[ring_wr] = m;
      ring_wr            = RING_W'((ring_wr + 1) % LOCK_DEPTH);
      ring_count++;
      r.status           = STAT_QUEUED;
    end else begin
      // Queue full: drop, state unchanged.
      r.status = STAT_DROPPED;
    end
    r.waiting_count = WCNT_W'(ring_count);
    return r;
  endfunction

  task automatic plan_checked(input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p,
                              input logic [STAT_W-1:0] st, input logic gv,
                              input logic [ADDR_W-1:0] ga, input logic [PORT_W-1:0] gp,
                              input logic [WCNT_W-1:0] wc);
    plan_row_t row;
    row.msg.addr           = a;
    row.msg.port           = p;
    row.reps               = 1;
    row.typed              = 1'b1;
    row.want.status        = st;
    row.want.grant_valid   = gv;
    row.want.grant_addr    = ga;
    row.want.grant_port    = gp;
    row.want.waiting_count = wc;
    plan.push_back(row);
  endtask

  task automatic plan_predicted(input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p,
                                input int unsigned reps);
    plan_row_t row;
    row.msg.addr = a;
    row.msg.port = p;
    row.reps     = reps;
    row.typed    = 1'b0;
    row.want     = '0;
    plan.push_back(row);
  endtask

  // Present one message after a random gap, hold it until accepted, then predict.
  // Leave valid high on return so a back-to-back message needs no second assignment.
  task automatic send_request(input req_t msg, output lock_result_t predicted);
    int unsigned gap;
    gap = feed_calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.sender_addr <= msg.addr;
    req_ch.sender_port <= msg.port;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = advance_lock(msg);
  endtask

  // Drop valid and hold off the sender until every status transaction is back.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string field, input logic [ENTRY_W-1:0] want,
                              input logic [ENTRY_W-1:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // Receiver: draw a stall per transaction, then hold ready until one is taken.
  initial begin
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = drain_calm ? 0 : $urandom_range(0, STALL_MAX);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Compare every accepted status transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: status transaction with nothing expected, expected none, actual %0d",
                 $time, rsp_ch.status);
      end else begin
        oldest = expected_results.pop_front();
        if (rsp_ch.status !== oldest.status)
          report_field("status", ENTRY_W'(oldest.status), ENTRY_W'(rsp_ch.status));
        if (rsp_ch.grant_valid !== oldest.grant_valid)
          report_field("grant_valid", ENTRY_W'(oldest.grant_valid),
                       ENTRY_W'(rsp_ch.grant_valid));
        if (rsp_ch.grant_addr !== oldest.grant_addr)
          report_field("grant_addr", ENTRY_W'(oldest.grant_addr),
                       ENTRY_W'(rsp_ch.grant_addr));
        if (rsp_ch.grant_port !== oldest.grant_port)
          report_field("grant_port", ENTRY_W'(oldest.grant_port),
                       ENTRY_W'(rsp_ch.grant_port));
        if (rsp_ch.waiting_count !== oldest.waiting_count)
          report_field("waiting_count", ENTRY_W'(oldest.waiting_count),
                       ENTRY_W'(rsp_ch.waiting_count));
      end
    end
  end

  // Watchdog: end the run once no transaction moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    lock_result_t      predicted;
    req_t              msg;
    int unsigned       release_pct;
    int unsigned       pick;
    logic [FLIP_W-1:0] flip;
    logic [POOL_W-1:0] who;

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.sender_addr <= '0;
    req_ch.sender_port <= '0;

    // Directed table. Hand-written rows cover reset, extremes and the drop code;
    // the rest go through the predictor.
    plan_checked(32'h0000_0000, 16'h0000, STAT_GRANTED, 1'b1, 32'h0000_0000, 16'h0000, 5'd0);
    plan_checked(32'h0000_0000, 16'h0000, STAT_RELEASE_IDLE, 1'b0, '0, '0, 5'd0);
    plan_checked(32'hFFFF_FFFF, 16'hFFFF, STAT_GRANTED, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 5'd0);
    // Same address as the holder, other port: not the holder, so it waits.
    plan_checked(32'hFFFF_FFFF, 16'h0000, STAT_QUEUED, 1'b0, '0, '0, 5'd1);
    // Same port as the holder, other address.
    plan_checked(32'h0000_0000, 16'hFFFF, STAT_QUEUED, 1'b0, '0, '0, 5'd2);
    plan_checked(32'hFFFF_FFFF, 16'hFFFF, STAT_RELEASE_NEXT, 1'b1, 32'hFFFF_FFFF, 16'h0000,
                 5'd1);
    plan_checked(32'hFFFF_FFFF, 16'h0000, STAT_RELEASE_NEXT, 1'b1, 32'h0000_0000, 16'hFFFF,
                 5'd0);
    plan_checked(32'h0000_0000, 16'hFFFF, STAT_RELEASE_IDLE, 1'b0, '0, '0, 5'd0);
    plan_predicted(32'h5A5A_C3C3, 16'h3C96, 1);
    // One requester asks again and again until the queue is full.
    plan_predicted(32'hA5A5_3C3C, 16'hC369, LOCK_DEPTH);
    // Full queue: dropped, and the count shows the full depth.
    plan_checked(32'h0000_0001, 16'h8000, STAT_DROPPED, 1'b0, '0, '0, 5'd16);
    plan_predicted(32'h5A5A_C3C3, 16'h3C96, 1);
    // New holder releases; its own repeat entry is next in line.
    plan_predicted(32'hA5A5_3C3C, 16'hC369, 1);

    // Requester pool: extremes, plus pairs that share an address or a port.
    foreach (requesters[i]) begin
      requesters[i].addr = $urandom;
      requesters[i].port = PORT_W'($urandom);
    end
    requesters[0]      = '1;
    requesters[1]      = '0;
    requesters[3].addr = requesters[2].addr;
    requesters[5].port = requesters[4].port;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      repeat (plan[i].reps) begin
        send_request(plan[i].msg, predicted);
        expected_results.push_back(plan[i].typed ? plan[i].want : predicted);
      end
    end
    hold_until_drained();

    // Random phases. The release share steers the queue: low fills it to the
    // drop point, high drains it back to an idle lock.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: release_pct = 5;
        1: release_pct = 25;
        2: release_pct = 50;
        default: release_pct = 85;
      endcase
      feed_calm  = ($urandom_range(0, 3) == 0);
      drain_calm = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (lock_held && pick < release_pct) begin
          msg = lock_owner;
        end else if (pick >= 95) begin
          // Noise: a near miss of the holder, or a stranger.
          if (lock_held && pick[0]) begin
            msg       = lock_owner;
            flip      = FLIP_W'($urandom_range(0, ENTRY_W - 1));
            msg[flip] = ~msg[flip];
          end else begin
            msg.addr = $urandom;
            msg.port = PORT_W'($urandom);
          end
        end else begin
          who = POOL_W'($urandom_range(0, POOL_SIZE - 1));
          msg = requesters[who];
        end
        send_request(msg, predicted);
        expected_results.push_back(predicted);
      end
      hold_until_drained();
    end

    feed_calm  = 1'b0;
    drain_calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
